FILE: rtl/aes_cmac_tag_engine_top_assert.svh
// Assertion macros used by the CMAC tag engine checker.
`ifndef AES_CMAC_TAG_ENGINE_TOP_ASSERT_SVH
`define AES_CMAC_TAG_ENGINE_TOP_ASSERT_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define ACMAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ACMAC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/acmac_pkg.sv
// Types, codes and AES helper functions for the CMAC tag engine.
package acmac_pkg;

  localparam int unsigned KeyHalfW = 64;
  localparam int unsigned BlockW   = 128;
  localparam int unsigned FillW    = 5;
  localparam int unsigned RndW     = 4;
  localparam int unsigned NumRnd   = 10;
  localparam int unsigned CfgIdxW  = 1;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_FINISH = 2'd1,
    OP_STAGE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APP_ENC,
    ST_STAGE_ENC,
    ST_FIN_L,
    ST_FIN_TAG,
    ST_FIN_OUT
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [KeyHalfW-1:0] tag_high;
    logic [KeyHalfW-1:0] tag_low;
  } out_t;

  localparam logic [7:0] CmacRb = 8'h87;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [RndW-1:0] rnd);
    case (rnd)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1b;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  // Byte 0 of a block sits in the top bits.
  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] b, input int unsigned i);
    get_byte = b[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [BlockW-1:0] key_expand(input logic [BlockW-1:0] rk,
                                                   input logic [7:0] rc);
    logic [31:0] tmp;
    logic [31:0] w0, w1, w2, w3;
    tmp = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0 = rk[127:96] ^ tmp;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    key_expand = {w0, w1, w2, w3};
  endfunction

  function automatic logic [BlockW-1:0] aes_round(input logic [BlockW-1:0] st,
                                                  input logic [BlockW-1:0] rk,
                                                  input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [BlockW-1:0] res;
    for (int i = 0; i < 16; i++) begin
      t[i] = SBOX[get_byte(st, (((i >> 2) + (i & 3)) & 3) * 4 + (i & 3))];
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      res[BlockW-1-8*i -: 8] = t[i];
    end
    aes_round = res ^ rk;
  endfunction

  function automatic logic [BlockW-1:0] cmac_dbl(input logic [BlockW-1:0] x);
    logic [BlockW-1:0] y;
    y = {x[BlockW-2:0], 1'b0};
    if (x[BlockW-1]) begin
      y[7:0] = y[7:0] ^ CmacRb;
    end
    cmac_dbl = y;
  endfunction

endpackage

FILE: rtl/aes_cmac_tag_engine_top.sv
// AES-128 CMAC tag engine with one iterative AES round unit.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/in_stall_o   | in_t: operation, data_byte
//  out     | output    | out_valid_o/out_stall_i | out_t: tag_high, tag_low
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An append stores its byte, or first folds a full buffer into the chain.
// A stage does one encryption; a finish two, plus any output register wait.
// The AES round unit does one round a cycle with on-the-fly key expansion.
// Reset clears the key, chaining value and fill count; no clearing pass.
// The input stalls while a request is at work; the tag waits in its register.
module aes_cmac_tag_engine_top import acmac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [KeyHalfW-1:0] cfg_data_i
);

  state_e state_q, state_d;
  logic [KeyHalfW-1:0] key_hi_q, key_lo_q;
  logic [BlockW-1:0]   chain_q, buf_q, st_q, rk_q;
  logic [FillW-1:0]    fill_q;
  logic [RndW-1:0]     rnd_q;
  logic [7:0]          byte_q;
  logic                out_valid_q;
  out_t                out_q;

  logic              in_fire, out_free, last_rnd, enc_act;
  logic [BlockW-1:0] key, rk_next, rnd_out, k1, k2, last_blk;

  assign key      = {key_hi_q, key_lo_q};
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_rnd = (rnd_q == RndW'(NumRnd));
  assign rk_next  = key_expand(rk_q, rcon(rnd_q));
  assign rnd_out  = aes_round(st_q, rk_next, last_rnd);

  // Last block: full buffer with K1, else padded buffer with K2.
  always_comb begin
    k1 = cmac_dbl(rnd_out);
    k2 = cmac_dbl(k1);
    for (int i = 0; i < 16; i++) begin
      if (fill_q[FillW-1] || (FillW'(i) < fill_q)) begin
        last_blk[BlockW-1-8*i -: 8] = get_byte(buf_q, i);
      end else if (FillW'(i) == fill_q) begin
        last_blk[BlockW-1-8*i -: 8] = PadByte;
      end else begin
        last_blk[BlockW-1-8*i -: 8] = 8'h00;
      end
    end
    last_blk = last_blk ^ (fill_q[FillW-1] ? k1 : k2);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (op_e'(in_data_i.operation))
            OP_APPEND: state_d = fill_q[FillW-1] ? ST_APP_ENC : ST_IDLE;
            OP_FINISH: state_d = ST_FIN_L;
            OP_STAGE:  state_d = ST_STAGE_ENC;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_APP_ENC, ST_STAGE_ENC: if (last_rnd) state_d = ST_IDLE;
      ST_FIN_L:   if (last_rnd) state_d = ST_FIN_TAG;
      ST_FIN_TAG: if (last_rnd) state_d = ST_FIN_OUT;
      ST_FIN_OUT: if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    cfg_ready_o = (state_q == ST_IDLE);
    enc_act     = (state_q == ST_APP_ENC) || (state_q == ST_STAGE_ENC) ||
                  (state_q == ST_FIN_L) || (state_q == ST_FIN_TAG);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_hi_q    <= '0;
      key_lo_q    <= '0;
      chain_q     <= '0;
      fill_q      <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_idx_e'(cfg_index_i))
          REG_KEY_HIGH: key_hi_q <= cfg_data_i;
          REG_KEY_LOW:  key_lo_q <= cfg_data_i;
          default: ;
        endcase
      end
      if ((state_q == ST_FIN_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (op_e'(in_data_i.operation))
              OP_APPEND: if (!fill_q[FillW-1]) fill_q <= fill_q + FillW'(1);
              OP_STAGE:  fill_q <= '0;
              default: ;
            endcase
            rnd_q <= RndW'(1);
          end
        end
        ST_APP_ENC, ST_STAGE_ENC, ST_FIN_L, ST_FIN_TAG: begin
          rnd_q <= last_rnd ? RndW'(1) : rnd_q + RndW'(1);
          if (last_rnd && (state_q == ST_APP_ENC)) begin
            chain_q <= rnd_out;
            fill_q  <= FillW'(1);
          end
          if (last_rnd && (state_q == ST_STAGE_ENC)) begin
            chain_q <= rnd_out;
          end
        end
        ST_FIN_OUT: begin
          if (out_free) begin
            chain_q     <= '0;
            fill_q      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: round state, round key, buffer, held byte and tag.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rk_q <= key;
          case (op_e'(in_data_i.operation))
            OP_APPEND: begin
              if (fill_q[FillW-1]) begin
                st_q   <= chain_q ^ buf_q ^ key;
                byte_q <= in_data_i.data_byte;
              end else begin
                buf_q[{~fill_q[3:0], 3'b000} +: 8] <= in_data_i.data_byte;
              end
            end
            OP_FINISH: st_q <= key;
            OP_STAGE:  st_q <= {{(BlockW-8){1'b0}}, in_data_i.data_byte} ^ key;
            default: ;
          endcase
        end
      end
      ST_FIN_L: begin
        if (last_rnd) begin
          st_q <= chain_q ^ last_blk ^ key;
          rk_q <= key;
        end else begin
          st_q <= rnd_out;
          rk_q <= rk_next;
        end
      end
      ST_FIN_OUT: if (out_free) out_q <= st_q;
      default: begin
        if (enc_act) begin
          st_q <= rnd_out;
          rk_q <= rk_next;
          if (last_rnd && (state_q == ST_APP_ENC)) begin
            buf_q[BlockW-1 -: 8] <= byte_q;
          end
        end
      end
    endcase
  end

endmodule

FILE: rtl/aes_cmac_tag_engine_top_chk.sv
// Port-level checker for the CMAC tag engine, bound to the top level.
`include "aes_cmac_tag_engine_top_assert.svh"

module acmac_chk import acmac_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o,
  input logic cfg_ready_o
);

  logic fin_req;
  assign fin_req = in_valid_i && !in_stall_o &&
                   (in_data_i.operation == OP_FINISH);

  `ACMAC_ASSERT_NEXT(a_fin_busy, clk_i, rst_ni, fin_req, in_stall_o)
  `ACMAC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o))
  `ACMAC_ASSERT_SAME(a_tag_after_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))
  `ACMAC_ASSERT_SAME(a_cfg_idle, clk_i, rst_ni, 1'b1, cfg_ready_o == !in_stall_o)

endmodule

bind aes_cmac_tag_engine_top acmac_chk u_acmac_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);

FILE: sim/cmac_tag_checker.sv
// Tag checker: predicts CMAC tags from observed requests and compares them with the block's output.
module cmac_tag_checker import acmac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_t                 in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_t                out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [KeyHalfW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  tags_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [KeyHalfW-1:0] key_hi, key_lo;
  logic [BlockW-1:0]   chain_blk, msg_blk;
  int                  fill;
  out_t                tag_q [$];

  function automatic logic [7:0] mul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] byte_at(input logic [BlockW-1:0] b, input int i);
    return b[BlockW-1-8*i -: 8];
  endfunction

  // AES-128 encryption, round keys expanded as the rounds go.
  function automatic logic [BlockW-1:0] encrypt(input logic [BlockW-1:0] pt,
                                                input logic [BlockW-1:0] key);
    logic [BlockW-1:0] st, rk;
    logic [7:0]        t [16];
    logic [7:0]        a0, a1, a2, a3, all, rc;
    logic [31:0]       sw, w0, w1, w2, w3;
    st = pt ^ key;
    rk = key;
    rc = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      sw = {SBOX[byte_at(rk, 13)] ^ rc, SBOX[byte_at(rk, 14)], SBOX[byte_at(rk, 15)],
            SBOX[byte_at(rk, 12)]};
      w0 = rk[127:96] ^ sw;
      w1 = rk[95:64] ^ w0;
      w2 = rk[63:32] ^ w1;
      w3 = rk[31:0] ^ w2;
      rk = {w0, w1, w2, w3};
      rc = mul2(rc);
      for (int i = 0; i < 16; i++)
        t[i] = SBOX[byte_at(st, (((i >> 2) + (i & 3)) & 3) * 4 + (i & 3))];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ mul2(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ mul2(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ mul2(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ mul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++)
        st[BlockW-1-8*i -: 8] = t[i];
      st = st ^ rk;
    end
    return st;
  endfunction

  function automatic logic [BlockW-1:0] gf_double(input logic [BlockW-1:0] x);
    logic [BlockW-1:0] y;
    y = {x[BlockW-2:0], 1'b0};
    if (x[BlockW-1]) y[7:0] = y[7:0] ^ 8'h87;
    return y;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic apply_request(input in_t req);
    logic [BlockW-1:0] key, k1, k2, last_blk, tag;
    key = {key_hi, key_lo};
    case (op_e'(req.operation))
      OP_APPEND: begin
        if (fill >= 16) begin
          chain_blk = encrypt(chain_blk ^ msg_blk, key);
          fill = 0;
        end
        msg_blk[BlockW-1-8*fill -: 8] = req.data_byte;
        fill++;
      end
      OP_STAGE: begin
        chain_blk = encrypt({120'b0, req.data_byte}, key);
        fill = 0;
      end
      OP_FINISH: begin
        k1 = gf_double(encrypt('0, key));
        if (fill == 16) begin
          last_blk = msg_blk ^ k1;
        end else begin
          k2 = gf_double(k1);
          last_blk = '0;
          for (int i = 0; i < fill; i++)
            last_blk[BlockW-1-8*i -: 8] = byte_at(msg_blk, i);
          last_blk[BlockW-1-8*fill -: 8] = 8'h80;
          last_blk = last_blk ^ k2;
        end
        tag = encrypt(chain_blk ^ last_blk, key);
        tag_q.push_back('{tag_high: tag[127:64], tag_low: tag[63:0]});
        chain_blk = '0;
        msg_blk = '0;
        fill = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      key_hi = '0;
      key_lo = '0;
      chain_blk = '0;
      msg_blk = '0;
      fill = 0;
      tag_q.delete();
      fail_count_o = 0;
      tags_pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (reg_idx_e'(cfg_index_i) == REG_KEY_HIGH) key_hi = cfg_data_i;
        else key_lo = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (tag_q.size() == 0) begin
          report_mismatch("unexpected tag_high", out_data_i.tag_high, '0);
        end else begin
          want = tag_q.pop_front();
          if (out_data_i.tag_high !== want.tag_high)
            report_mismatch("tag_high", out_data_i.tag_high, want.tag_high);
          if (out_data_i.tag_low !== want.tag_low)
            report_mismatch("tag_low", out_data_i.tag_low, want.tag_low);
        end
      end
      if (in_valid_i && !in_stall_i) apply_request(in_data_i);
      tags_pending_o = tag_q.size();
    end
  end
endmodule

FILE: sim/tb.sv
// Testbench top: clock, reset, request stimulus, key writes and the verdict.
module tb import acmac_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  logic                clk, rst_n;
  logic                in_valid, in_stall;
  in_t                 in_data;
  logic                out_valid, out_stall;
  out_t                out_data;
  logic                cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [KeyHalfW-1:0] cfg_data;
  int                  fail_count, tags_pending;
  int                  send_idle_pct, recv_stall_pct, hold_cycles, cycles;

  aes_cmac_tag_engine_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  cmac_tag_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .tags_pending_o(tags_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send(input op_e op, input logic [7:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, data_byte: value};
    #1;
    while (in_stall) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tags_pending != 0) @(negedge clk);
    // let a trailing append's block fold finish
    repeat (30) @(negedge clk);
  endtask

  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    drain();
    for (int r = 0; r < 2; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (r == 0) ? REG_KEY_HIGH : REG_KEY_LOW;
      cfg_data <= (r == 0) ? hi : lo;
      #1;
      while (!cfg_ready) begin
        @(negedge clk);
        #1;
      end
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send(OP_APPEND, 8'($urandom));
    send(OP_FINISH, 8'($urandom));
  endtask

  // Mostly well-formed messages; some staged, some with unused codes mixed in.
  task automatic random_traffic(input int n_items);
    int sent, len, pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        send(OP_NONE, 8'($urandom));
        sent++;
      end else begin
        if (pick < 3) begin
          send(OP_STAGE, 8'($urandom));
          sent++;
        end
        case ($urandom_range(3))
          0:       len = 16 * $urandom_range(2);
          1:       len = $urandom_range(3);
          default: len = $urandom_range(40);
        endcase
        send_message(len);
        sent += len + 1;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_KEY_HIGH;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty message under the reset key, then a standard key.
    send(OP_FINISH, 8'h00);
    write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send(OP_FINISH, 8'hff);
    for (int i = 0; i < 16; i++) send(OP_APPEND, (i == 0) ? 8'h00 : 8'hff);
    send(OP_FINISH, 8'h00);
    send(OP_NONE, 8'hff);
    send(OP_STAGE, 8'hff);
    send(OP_APPEND, 8'hff);
    send(OP_STAGE, 8'h00);
    send(OP_APPEND, 8'h80);
    send(OP_FINISH, 8'h00);
    drain();

    write_key('0, '0);
    random_traffic(100);
    write_key('1, '1);
    send_idle_pct = 60;
    random_traffic(100);
    write_key(64'($urandom) << 32 | 64'($urandom), 64'($urandom) << 32 | 64'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 60;
    hold_cycles = 300;
    random_traffic(100);
    write_key(64'($urandom) << 32 | 64'($urandom), 64'($urandom) << 32 | 64'($urandom));
    send_idle_pct = 34;
    recv_stall_pct = 34;
    random_traffic(100);

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/acmac_pkg.sv
rtl/aes_cmac_tag_engine_top.sv
rtl/aes_cmac_tag_engine_top_chk.sv
sim/cmac_tag_checker.sv
sim/tb.sv
